/* hdl/phbm_pkg.sv */
// ----------------------------------------------------------------------------
// phbm_pkg
// Shared types, constants and helper functions of the peak-hold bar meter.
// ----------------------------------------------------------------------------
package phbm_pkg;

    // number of bar segments and derived widths
    localparam int SEGMENTS     = 16;
    localparam int SEG_MUL_W    = $clog2(SEGMENTS + 1);
    localparam int SEG_PROD_W   = 13 + SEG_MUL_W;
    localparam int SEG_IDX_W    = SEG_PROD_W - 12;

    // field widths
    localparam int RAW_W        = 16;
    localparam int GAIN_W       = 10;
    localparam int HOLD_W       = 8;
    localparam int LVL_W        = 13;
    localparam int PROD_W       = RAW_W + GAIN_W;
    localparam int MASK_W       = 16;
    localparam int CNT5_W       = 5;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    // full scale is 1.0 in Q.12
    localparam logic [LVL_W-1:0]  FULL_SCALE  = 13'd4096;
    localparam logic [HOLD_W-1:0] CNT_MAX     = 8'd255;
    localparam logic [CNT5_W-1:0] SAT5_MAX    = 5'd31;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST    = 10'd640;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 8'd40;
    localparam logic [LVL_W-1:0]  DECAY_RST   = 13'd102;
    localparam logic [LVL_W-1:0]  SHOW_RST    = 13'd205;

    // register indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_HOLD  = 2'd1,
        REG_DECAY = 2'd2,
        REG_SHOW  = 2'd3
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] gain_q8;
        logic [HOLD_W-1:0] hold_frames;
        logic [LVL_W-1:0]  decay_step;
        logic [LVL_W-1:0]  peak_show_level;
    } cfg_t;

    // floor(v * SEGMENTS / 4096)
    function automatic logic [SEG_IDX_W-1:0] seg_index(input logic [LVL_W-1:0] v);
        logic [SEG_PROD_W-1:0] p;
        begin
            p = SEG_PROD_W'(v) * SEG_PROD_W'(SEGMENTS);
            return p[SEG_PROD_W-1:12];
        end
    endfunction

    // clamp a segment index to the 5-bit field
    function automatic logic [CNT5_W-1:0] sat5(input logic [SEG_IDX_W-1:0] v);
        begin
            if (v > SEG_IDX_W'(SAT5_MAX))
                return SAT5_MAX;
            else
                return CNT5_W'(v);
        end
    endfunction

    // thermometer mask of lit segments
    function automatic logic [MASK_W-1:0] bar_mask(input logic [SEG_IDX_W-1:0] lit);
        logic [MASK_W-1:0] m;
        begin
            m = '0;
            for (int i = 0; i < MASK_W; i++)
                m[i] = (SEG_IDX_W'(i) < lit);
            return m;
        end
    endfunction

endpackage

/* hdl/phbm_regs.sv */
// ----------------------------------------------------------------------------
// phbm_regs
// APB configuration registers: gain, hold time, decay step, show threshold.
// ----------------------------------------------------------------------------
module phbm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phbm_pkg::ADDR_W-1:0]   paddr,
    input  logic [phbm_pkg::DATA_W-1:0]   pwdata,
    output logic [phbm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output phbm_pkg::cfg_t                cfg
);
    import phbm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q8         <= GAIN_RST;
            cfg_reg.hold_frames     <= HOLD_RST;
            cfg_reg.decay_step      <= DECAY_RST;
            cfg_reg.peak_show_level <= SHOW_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN:  cfg_reg.gain_q8         <= pwdata[GAIN_W-1:0];
                REG_HOLD:  cfg_reg.hold_frames     <= pwdata[HOLD_W-1:0];
                REG_DECAY: cfg_reg.decay_step      <= pwdata[LVL_W-1:0];
                REG_SHOW:  cfg_reg.peak_show_level <= pwdata[LVL_W-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_GAIN:  prdata = DATA_W'(cfg_reg.gain_q8);
            REG_HOLD:  prdata = DATA_W'(cfg_reg.hold_frames);
            REG_DECAY: prdata = DATA_W'(cfg_reg.decay_step);
            REG_SHOW:  prdata = DATA_W'(cfg_reg.peak_show_level);
            default:   prdata = '0;
        endcase
    end

endmodule

/* hdl/phbm_gain.sv */
// ----------------------------------------------------------------------------
// phbm_gain
// Input register, then gain multiply and saturation to full scale.
// ----------------------------------------------------------------------------
module phbm_gain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [phbm_pkg::RAW_W-1:0]    level_in,
    input  logic [phbm_pkg::GAIN_W-1:0]   gain_q8,
    output logic                          lvl_valid,
    input  logic                          lvl_ready,
    output logic [phbm_pkg::LVL_W-1:0]    lvl
);
    import phbm_pkg::*;

    logic                raw_valid_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic                lvl_valid_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic                lvl_take;
    logic                raw_take;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-13:0]  scaled;
    logic [LVL_W-1:0]    lvl_next;

    assign lvl_take  = !lvl_valid_reg || lvl_ready;
    assign raw_take  = !raw_valid_reg || lvl_take;
    assign in_ready  = raw_take;
    assign lvl_valid = lvl_valid_reg;
    assign lvl       = lvl_reg;

    // Q0.16 times Q2.8 gives Q2.24; keep Q.12 and clamp at 1.0
    always_comb
    begin
        prod   = PROD_W'(raw_reg) * PROD_W'(gain_q8);
        scaled = prod[PROD_W-1:12];
        if (scaled > (PROD_W-12)'(FULL_SCALE))
            lvl_next = FULL_SCALE;
        else
            lvl_next = scaled[LVL_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg <= 1'b0;
            lvl_valid_reg <= 1'b0;
        end
        else
        begin
            if (raw_take)
                raw_valid_reg <= in_valid;
            if (lvl_take)
                lvl_valid_reg <= raw_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (raw_take && in_valid)
            raw_reg <= level_in;
        if (lvl_take && raw_valid_reg)
            lvl_reg <= lvl_next;
    end

endmodule

/* hdl/phbm_peak.sv */
// ----------------------------------------------------------------------------
// phbm_peak
// Peak-hold state update and result register with bar segment outputs.
// ----------------------------------------------------------------------------
module phbm_peak (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phbm_pkg::cfg_t                cfg,
    input  logic                          lvl_valid,
    output logic                          lvl_ready,
    input  logic [phbm_pkg::LVL_W-1:0]    lvl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [phbm_pkg::LVL_W-1:0]    level_now,
    output logic [phbm_pkg::LVL_W-1:0]    peak_value,
    output logic [phbm_pkg::MASK_W-1:0]   lit_mask,
    output logic [phbm_pkg::CNT5_W-1:0]   lit_count,
    output logic [phbm_pkg::CNT5_W-1:0]   peak_segment,
    output logic                          peak_shown
);
    import phbm_pkg::*;

    logic [LVL_W-1:0]      held_peak_reg;
    logic [HOLD_W-1:0]     hold_cnt_reg;
    logic [LVL_W-1:0]      held_peak_next;
    logic [HOLD_W-1:0]     hold_cnt_next;
    logic                  out_valid_reg;
    logic [LVL_W-1:0]      level_now_reg;
    logic [MASK_W-1:0]     lit_mask_reg;
    logic [CNT5_W-1:0]     lit_count_reg;
    logic [CNT5_W-1:0]     peak_seg_reg;
    logic                  peak_shown_reg;
    logic                  out_take;
    logic                  upd;
    logic [SEG_IDX_W-1:0]  lit_idx;
    logic [SEG_IDX_W-1:0]  pseg_idx;

    assign out_take  = !out_valid_reg || out_ready;
    assign lvl_ready = out_take;
    assign upd       = lvl_valid && out_take;

    assign out_valid    = out_valid_reg;
    assign level_now    = level_now_reg;
    assign peak_value   = held_peak_reg;
    assign lit_mask     = lit_mask_reg;
    assign lit_count    = lit_count_reg;
    assign peak_segment = peak_seg_reg;
    assign peak_shown   = peak_shown_reg;

    // new peak captures and restarts the hold, else count, and decay once past hold_frames
    always_comb
    begin
        held_peak_next = held_peak_reg;
        hold_cnt_next  = hold_cnt_reg;
        if (lvl > held_peak_reg)
        begin
            held_peak_next = lvl;
            hold_cnt_next  = '0;
        end
        else
        begin
            if (hold_cnt_reg != CNT_MAX)
                hold_cnt_next = hold_cnt_reg + 1'b1;
            if (hold_cnt_next > cfg.hold_frames)
            begin
                if (held_peak_reg > cfg.decay_step)
                    held_peak_next = held_peak_reg - cfg.decay_step;
                else
                    held_peak_next = '0;
            end
        end
        lit_idx  = seg_index(lvl);
        pseg_idx = seg_index(held_peak_next);
    end

    // control state and peak tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_peak_reg <= '0;
            hold_cnt_reg  <= '0;
        end
        else
        begin
            if (out_take)
                out_valid_reg <= lvl_valid;
            if (upd)
            begin
                held_peak_reg <= held_peak_next;
                hold_cnt_reg  <= hold_cnt_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            level_now_reg  <= lvl;
            lit_mask_reg   <= bar_mask(lit_idx);
            lit_count_reg  <= sat5(lit_idx);
            peak_seg_reg   <= sat5(pseg_idx);
            peak_shown_reg <= (held_peak_next > cfg.peak_show_level) &&
                              (pseg_idx < SEG_IDX_W'(SEGMENTS));
        end
    end

endmodule

/* hdl/peak_hold_bar_meter_core.sv */
// ----------------------------------------------------------------------------
// peak_hold_bar_meter_core
// Level meter: gain and clamp, peak hold with decay, bar segment outputs.
// ----------------------------------------------------------------------------
// an accepted item passes the input, level and result registers in order
// throughput: one item per cycle while out_ready holds
// input and level registers take new items while a result waits, until full
// reset: registers return to gain 640, hold 40, decay 102, show level 205;
// held peak and hold counter clear to zero, no item in flight
module peak_hold_bar_meter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phbm_pkg::ADDR_W-1:0]   paddr,
    input  logic [phbm_pkg::DATA_W-1:0]   pwdata,
    output logic [phbm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [phbm_pkg::RAW_W-1:0]    level_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [phbm_pkg::LVL_W-1:0]    level_now,
    output logic [phbm_pkg::LVL_W-1:0]    peak_value,
    output logic [phbm_pkg::MASK_W-1:0]   lit_mask,
    output logic [phbm_pkg::CNT5_W-1:0]   lit_count,
    output logic [phbm_pkg::CNT5_W-1:0]   peak_segment,
    output logic                          peak_shown
);
    import phbm_pkg::*;

    cfg_t              cfg;
    logic              lvl_valid;
    logic              lvl_ready;
    logic [LVL_W-1:0]  lvl;

    // configuration registers
    phbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // gain and clamp stage
    phbm_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level_in  (level_in),
        .gain_q8   (cfg.gain_q8),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl)
    );

    // peak hold and result stage
    phbm_peak u_peak (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .lvl_valid    (lvl_valid),
        .lvl_ready    (lvl_ready),
        .lvl          (lvl),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .level_now    (level_now),
        .peak_value   (peak_value),
        .lit_mask     (lit_mask),
        .lit_count    (lit_count),
        .peak_segment (peak_segment),
        .peak_shown   (peak_shown)
    );

endmodule

/* hdl/phbm_checker.sv */
// ----------------------------------------------------------------------------
// phbm_checker
// Port-level checks of the peak-hold bar meter, bound to the top level.
// ----------------------------------------------------------------------------
module phbm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phbm_pkg::ADDR_W-1:0]   paddr,
    input  logic [phbm_pkg::DATA_W-1:0]   pwdata,
    input  logic [phbm_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [phbm_pkg::RAW_W-1:0]    level_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [phbm_pkg::LVL_W-1:0]    level_now,
    input  logic [phbm_pkg::LVL_W-1:0]    peak_value,
    input  logic [phbm_pkg::MASK_W-1:0]   lit_mask,
    input  logic [phbm_pkg::CNT5_W-1:0]   lit_count,
    input  logic [phbm_pkg::CNT5_W-1:0]   peak_segment,
    input  logic                          peak_shown
);
    import phbm_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level_now) && $stable(peak_value))
        else $error("result changed while stalled");

    // level never exceeds full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_now <= FULL_SCALE && peak_value <= FULL_SCALE)
        else $error("level or peak above full scale");

    // lit mask has as many set bits as lit_count
    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(lit_mask) == int'(lit_count))
        else $error("lit mask does not match lit count");

    // a shown peak lies on a real segment
    a_peak_seg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && peak_shown |-> int'(peak_segment) < SEGMENTS)
        else $error("peak shown beyond the top segment");

endmodule

bind peak_hold_bar_meter_core phbm_checker u_phbm_checker (.*);
